>>> src/imb_pkg.sv
// ----------------------------------------------------------------------------
// imb_pkg
// Shared widths, mode codes and angle wrap limits for the IMU bias
// calibration and rate integration block.
// ----------------------------------------------------------------------------
package imb_pkg;

    localparam int SMP_W   = 16;   // raw sample width
    localparam int RATE_W  = 17;   // corrected rate width
    localparam int SUM_W   = 32;   // calibration sums, totals, count
    localparam int ANGLE_W = 24;   // integrated angle width
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

    // angle wraps into [-ANGLE_MAX, ANGLE_MAX]
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 24'sd4718592;
    localparam logic signed [ANGLE_W:0]   ANGLE_SPAN = 25'sd9437184;

endpackage

>>> src/imu_bias_calibrate_integrate.sv
// ----------------------------------------------------------------------------
// imu_bias_calibrate_integrate
// Gyro/accel bias calibration by running average and bias-corrected
// integration of gyro rates and accelerometer values.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_accel_x/y/z, i_gyro_x/y/z
//  out       output     o_out_valid / i_out_stall o_rate_*, o_accel_total_*, o_angle_*
//  cfg       input      i_cfg_we                  i_cfg_data (mode)
//
//  Idle and running items go straight to DONE; so does a calibrating item whose
//  count wraps. Other calibrating items run DLOAD, DITER and DSTORE per axis:
//  the six bias divisions share one restoring divider, one quotient bit per cycle.
//  Reset (synchronous, active low) clears all sums, biases, totals and angles.
//  A new item is accepted while the previous result still waits on a stall;
//  the finished result then holds until the output register frees up.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_integrate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imb_pkg::MODE_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_accel_x,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_accel_y,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_accel_z,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_gyro_x,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_gyro_y,
    input  logic signed [imb_pkg::SMP_W-1:0]    i_gyro_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [imb_pkg::RATE_W-1:0]   o_rate_x,
    output logic signed [imb_pkg::RATE_W-1:0]   o_rate_y,
    output logic signed [imb_pkg::RATE_W-1:0]   o_rate_z,
    output logic signed [imb_pkg::SUM_W-1:0]    o_accel_total_x,
    output logic signed [imb_pkg::SUM_W-1:0]    o_accel_total_y,
    output logic signed [imb_pkg::SUM_W-1:0]    o_accel_total_z,
    output logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_x,
    output logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_y,
    output logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_z
);
    import imb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DLOAD  = 3'd1;
    localparam logic [2:0] S_DITER  = 3'd2;
    localparam logic [2:0] S_DSTORE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int         NAXIS    = 6;   // 0..2 gyro, 3..5 accel
    localparam logic [2:0] AX_LAST  = 3'd5;

    logic [2:0]               r_state;
    logic [MODE_W-1:0]        r_mode;
    logic [SUM_W-1:0]         r_cal_sum [NAXIS];
    logic [SUM_W-1:0]         r_count;
    logic signed [SMP_W-1:0]  r_bias [NAXIS];
    logic [SUM_W-1:0]         r_total [3];
    logic signed [ANGLE_W-1:0] r_angle [3];
    logic signed [RATE_W-1:0] r_rate [3];

    // shared divider
    logic [2:0]               r_axis;
    logic [4:0]               r_bit;
    logic                     r_neg;
    logic [SUM_W-1:0]         r_quo;
    logic [SUM_W:0]           r_rem;

    // output register
    logic                     r_ovalid;
    logic signed [RATE_W-1:0] r_orate [3];
    logic [SUM_W-1:0]         r_ototal [3];
    logic signed [ANGLE_W-1:0] r_oangle [3];

    logic signed [SMP_W-1:0]  w_acc [3];
    logic signed [SMP_W-1:0]  w_gyr [3];
    logic signed [RATE_W-1:0] w_a [3];
    logic signed [RATE_W-1:0] w_v [3];
    logic signed [ANGLE_W:0]  w_s [3];
    logic signed [ANGLE_W:0]  w_sw [3];
    logic [SUM_W-1:0]         n_count;
    logic                     w_accept;
    logic                     w_oload;
    logic [SUM_W-1:0]         w_dsel;
    logic [SUM_W:0]           w_trial;
    logic                     w_ge;

    assign w_acc[0] = i_accel_x;
    assign w_acc[1] = i_accel_y;
    assign w_acc[2] = i_accel_z;
    assign w_gyr[0] = i_gyro_x;
    assign w_gyr[1] = i_gyro_y;
    assign w_gyr[2] = i_gyro_z;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_oload    = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);
    assign n_count    = r_count + 32'd1;

    // running-mode lanes, one per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = RATE_W'(w_acc[i]) - RATE_W'(r_bias[3+i]);
            w_v[i] = RATE_W'(w_gyr[i]) - RATE_W'(r_bias[i]);
            w_s[i] = (ANGLE_W+1)'(r_angle[i]) + (ANGLE_W+1)'(w_v[i]);
            if (w_s[i] > (ANGLE_W+1)'(ANGLE_MAX)) begin
                w_sw[i] = w_s[i] - ANGLE_SPAN;
            end else if (w_s[i] < -((ANGLE_W+1)'(ANGLE_MAX))) begin
                w_sw[i] = w_s[i] + ANGLE_SPAN;
            end else begin
                w_sw[i] = w_s[i];
            end
        end
    end

    // restoring divider step: magnitude / count, one bit per cycle
    assign w_dsel  = r_cal_sum[r_axis];
    assign w_trial = {r_rem[SUM_W-1:0], r_quo[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_axis   <= '0;
            for (int i = 0; i < NAXIS; i++) begin
                r_cal_sum[i] <= '0;
                r_bias[i]    <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_total[i] <= '0;
                r_angle[i] <= '0;
                r_rate[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end

            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_mode == MODE_CAL) begin
                            for (int i = 0; i < 3; i++) begin
                                r_cal_sum[i]   <= r_cal_sum[i] + SUM_W'(w_gyr[i]);
                                r_cal_sum[3+i] <= r_cal_sum[3+i] + SUM_W'(w_acc[i]);
                            end
                            r_count <= n_count;
                            r_axis  <= '0;
                            // wrapped count leaves the biases as they were
                            r_state <= (n_count != '0) ? S_DLOAD : S_DONE;
                        end else begin
                            r_state <= S_DONE;
                            if (r_mode == MODE_RUN) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_total[i] <= r_total[i] + SUM_W'(w_a[i]);
                                    r_rate[i]  <= w_v[i];
                                    r_angle[i] <= w_sw[i][ANGLE_W-1:0];
                                end
                            end
                        end
                    end
                end
                S_DLOAD: begin
                    r_state <= S_DITER;
                end
                S_DITER: begin
                    if (r_bit == '0) begin
                        r_state <= S_DSTORE;
                    end
                end
                S_DSTORE: begin
                    r_bias[r_axis] <= r_neg ? SMP_W'(32'd0 - r_quo) : r_quo[SMP_W-1:0];
                    if (r_axis == AX_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= r_axis + 3'd1;
                        r_state <= S_DLOAD;
                    end
                end
                S_DONE: begin
                    if (w_oload) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_DLOAD) begin
            r_neg <= w_dsel[SUM_W-1];
            r_quo <= w_dsel[SUM_W-1] ? (32'd0 - w_dsel) : w_dsel;
            r_rem <= '0;
            r_bit <= 5'd31;
        end else if (r_state == S_DITER) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_count}) : w_trial;
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_bit <= r_bit - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            for (int i = 0; i < 3; i++) begin
                r_orate[i]  <= r_rate[i];
                r_ototal[i] <= r_total[i];
                r_oangle[i] <= r_angle[i];
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_rate_x        = r_orate[0];
    assign o_rate_y        = r_orate[1];
    assign o_rate_z        = r_orate[2];
    assign o_accel_total_x = $signed(r_ototal[0]);
    assign o_accel_total_y = $signed(r_ototal[1]);
    assign o_accel_total_z = $signed(r_ototal[2]);
    assign o_angle_x       = r_oangle[0];
    assign o_angle_y       = r_oangle[1];
    assign o_angle_z       = r_oangle[2];

endmodule

>>> src/imb_checker.sv
// ----------------------------------------------------------------------------
// imb_checker
// Port-level checks for the IMU bias calibration and integration block.
// ----------------------------------------------------------------------------
module imb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [imb_pkg::RATE_W-1:0]   o_rate_x,
    input  logic signed [imb_pkg::SUM_W-1:0]    o_accel_total_x,
    input  logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_x,
    input  logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_y,
    input  logic signed [imb_pkg::ANGLE_W-1:0]  o_angle_z
);
    import imb_pkg::*;

    // one item in flight: an accepted item blocks the input next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accept");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle_x <= ANGLE_MAX) && (o_angle_x >= -ANGLE_MAX)
                     && (o_angle_y <= ANGLE_MAX) && (o_angle_y >= -ANGLE_MAX)
                     && (o_angle_z <= ANGLE_MAX) && (o_angle_z >= -ANGLE_MAX))
        else $error("angle outside wrap range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_angle_z)
            && $stable(o_accel_total_x) && $stable(o_rate_x))
        else $error("stalled result changed");

endmodule

bind imu_bias_calibrate_integrate imb_checker u_imb_checker (.*);
